// File: hw/rtl/twicd_pkg.sv
// Shared types and constants of the two-wire clock divider calculator.
package twicd_pkg;

  localparam int unsigned FclkW  = 30;
  localparam int unsigned RateW  = 22;
  localparam int unsigned NsW    = 16;
  localparam int unsigned DenW   = RateW + 1;
  localparam int unsigned DivSteps = FclkW;
  localparam int unsigned WordW  = 29;

  // reciprocal of 125 for (fclk >> 3) / 125, exact after one correction
  localparam logic [27:0] RecipK   = 28'd137438953;
  localparam int unsigned RecipKSh = 34;
  // reciprocal of 15625 for ((p + 999999) >> 6) / 15625
  localparam logic [20:0] RecipM   = 21'd1099511;
  localparam int unsigned RecipMSh = 34;

  localparam logic [2:0] CfgFclk    = 3'd0;
  localparam logic [2:0] CfgOffset  = 3'd1;
  localparam logic [2:0] CfgPmax    = 3'd2;
  localparam logic [2:0] CfgHoldEn  = 3'd3;
  localparam logic [2:0] CfgFiltEn  = 3'd4;

  typedef struct packed {
    logic [FclkW-1:0] fclk;
    logic [3:0]       offset;
    logic [2:0]       pmax;
    logic             hold_en;
    logic             filt_en;
  } cfg_t;

  // one divider pipeline word: partial remainder, dividend/quotient shifter
  typedef struct packed {
    logic             rate_zero;
    logic [DenW-1:0]  den;
    logic [DenW-1:0]  rem;
    logic [FclkW-1:0] num;
    logic [NsW-1:0]   hold_ns;
    logic [NsW-1:0]   filt_ns;
  } div_t;

endpackage

// File: hw/rtl/twicd_div_stage.sv
// One restoring-division step of the half-period divider pipeline.
module twicd_div_stage import twicd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t d_i,
  output logic valid_o,
  output div_t d_o
);

  logic [DenW:0] r;
  logic          ge;
  logic          valid_q;
  div_t          d_q;

  always_comb begin
    r  = {d_i.rem, d_i.num[FclkW-1]};
    ge = (r >= {1'b0, d_i.den});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q.rate_zero <= d_i.rate_zero;
      d_q.den       <= d_i.den;
      d_q.rem       <= ge ? DenW'(r - {1'b0, d_i.den}) : r[DenW-1:0];
      d_q.num       <= {d_i.num[FclkW-2:0], ge};
      d_q.hold_ns   <= d_i.hold_ns;
      d_q.filt_ns   <= d_i.filt_ns;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

// File: hw/rtl/twicd_post.sv
// Prescaler split, hold and filter count pipeline after the divider.
module twicd_post import twicd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  div_t             d_i,
  output logic             valid_o,
  output logic [WordW-1:0] waveform_word_o,
  output logic [2:0]       filter_threshold_o,
  output logic             prescaler_clamped_o,
  output logic             hold_clamped_o,
  output logic             filter_clamped_o
);

  logic [5:0] vld_q;

  // stage 1
  logic [FclkW-1:0] half;
  logic [FclkW-1:0] dv_d, dv_q;
  logic [26:0]      x;
  logic [54:0]      kp;
  logic [20:0]      k0_q;
  logic             rz1_q;
  logic [NsW-1:0]   hns1_q, fns1_q;

  // stage 2
  logic [27:0]      kr;
  logic [20:0]      k_d, k_q;
  logic [21:0]      v;
  logic [4:0]       presc;
  logic [FclkW-1:0] dsh;
  logic [2:0]       pr_d, pr_q2;
  logic [7:0]       dvr_d, dvr_q2;
  logic             pf_d, pf_q2;
  logic [NsW-1:0]   hns2_q, fns2_q;

  // stage 3
  logic [36:0]      ph_q, pf3_q;
  logic [2:0]       pr_q3;
  logic [7:0]       dvr_q3;
  logic             pf_q3;

  // stage 4
  logic [25:0]      sh, sf;
  logic [26:0]      ah, af;
  logic [20:0]      yh_q, yf_q;
  logic [2:0]       pr_q4;
  logic [7:0]       dvr_q4;
  logic             pf_q4;

  // stage 5
  logic [41:0]      mh, mf;
  logic [7:0]       qh0_q, qf0_q;
  logic [20:0]      yh5_q, yf5_q;
  logic [2:0]       pr_q5;
  logic [7:0]       dvr_q5;
  logic             pf_q5;

  // stage 6
  logic [21:0]      rh, rf;
  logic [7:0]       qh, qf;
  logic [4:0]       hold_d;
  logic             hflag_d;
  logic [2:0]       filt_d;
  logic             fflag_d;
  logic [WordW-1:0] word_q;
  logic [2:0]       filt_q;
  logic             pflag_q, hflag_q, fflag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // stage 1: ceil, offset, fclk/1000 estimate
  always_comb begin
    half = d_i.num + FclkW'(d_i.rem != '0);
    dv_d = (half > FclkW'(cfg_i.offset)) ? half - FclkW'(cfg_i.offset) : '0;
    x    = cfg_i.fclk[FclkW-1:3];
    kp   = 55'(x) * 55'(RecipK);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q   <= dv_d;
      k0_q   <= kp[RecipKSh +: 21];
      rz1_q  <= d_i.rate_zero;
      hns1_q <= d_i.hold_ns;
      fns1_q <= d_i.filt_ns;
    end
  end

  // stage 2: prescaler split and fclk/1000 correction
  always_comb begin
    kr  = 28'(x) - (28'(k0_q) * 28'd125);
    k_d = (kr >= 28'd125) ? k0_q + 21'd1 : k0_q;
    v   = dv_q[FclkW-1:8];
    presc = '0;
    for (int i = 0; i < 22; i++) begin
      if (v[i]) presc = 5'(i + 1);
    end
    dsh = dv_q >> presc;
    if (rz1_q || (presc > 5'(cfg_i.pmax))) begin
      pr_d  = cfg_i.pmax;
      dvr_d = 8'hff;
      pf_d  = 1'b1;
    end else begin
      pr_d  = presc[2:0];
      dvr_d = dsh[7:0];
      pf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q    <= k_d;
      pr_q2  <= pr_d;
      dvr_q2 <= dvr_d;
      pf_q2  <= pf_d;
      hns2_q <= hns1_q;
      fns2_q <= fns1_q;
    end
  end

  // stage 3: ns times clocks per millisecond
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= 37'(hns2_q) * 37'(k_q);
      pf3_q  <= 37'(fns2_q) * 37'(k_q);
      pr_q3  <= pr_q2;
      dvr_q3 <= dvr_q2;
      pf_q3  <= pf_q2;
    end
  end

  // stage 4: saturate (anything that large clamps anyway), round up
  always_comb begin
    sh = (ph_q[36:26] != '0) ? '1 : ph_q[25:0];
    sf = (pf3_q[36:26] != '0) ? '1 : pf3_q[25:0];
    ah = 27'(sh) + 27'd999999;
    af = 27'(sf) + 27'd999999;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yh_q   <= ah[26:6];
      yf_q   <= af[26:6];
      pr_q4  <= pr_q3;
      dvr_q4 <= dvr_q3;
      pf_q4  <= pf_q3;
    end
  end

  // stage 5: quotient estimate by 15625
  always_comb begin
    mh = 42'(yh_q) * 42'(RecipM);
    mf = 42'(yf_q) * 42'(RecipM);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qh0_q  <= mh[RecipMSh +: 8];
      qf0_q  <= mf[RecipMSh +: 8];
      yh5_q  <= yh_q;
      yf5_q  <= yf_q;
      pr_q5  <= pr_q4;
      dvr_q5 <= dvr_q4;
      pf_q5  <= pf_q4;
    end
  end

  // stage 6: correct, clamp, pack
  always_comb begin
    rh = 22'(yh5_q) - (22'(qh0_q) * 22'd15625);
    rf = 22'(yf5_q) - (22'(qf0_q) * 22'd15625);
    qh = (rh >= 22'd15625) ? qh0_q + 8'd1 : qh0_q;
    qf = (rf >= 22'd15625) ? qf0_q + 8'd1 : qf0_q;
    hold_d  = '0;
    hflag_d = 1'b0;
    filt_d  = '0;
    fflag_d = 1'b0;
    if (cfg_i.hold_en && (qh > 8'd3)) begin
      if (qh > 8'd34) begin
        hold_d  = 5'h1f;
        hflag_d = 1'b1;
      end else begin
        hold_d  = 5'(qh - 8'd3);
      end
    end
    if (cfg_i.filt_en) begin
      if (qf > 8'd7) begin
        filt_d  = 3'd7;
        fflag_d = 1'b1;
      end else begin
        filt_d  = qf[2:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q  <= {hold_d, 5'b0, pr_q5, dvr_q5, dvr_q5};
      filt_q  <= filt_d;
      pflag_q <= pf_q5;
      hflag_q <= hflag_d;
      fflag_q <= fflag_d;
    end
  end

  assign valid_o             = vld_q[5];
  assign waveform_word_o     = word_q;
  assign filter_threshold_o  = filt_q;
  assign prescaler_clamped_o = pflag_q;
  assign hold_clamped_o      = hflag_q;
  assign filter_clamped_o    = fflag_q;

endmodule

// File: hw/rtl/twi_clock_divider_calc.sv
// Top level of the two-wire bus clock divider calculator.
// Each request word gives a bus rate and hold/filter times in ns; the result word carries
// the packed waveform word, the filter threshold and three saturation flags. The block is
// a 36-stage pipeline (30 one-bit restoring division steps for the half-period count,
// then 6 stages of prescaler split and reciprocal multiplies), and a new request is taken
// every cycle unless the pipeline holds. The whole pipeline advances together: it holds
// while the result register is full and not taken. Configuration writes are always
// ready and take effect at once; write them only with the pipeline empty.
module twi_clock_divider_calc import twicd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [FclkW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RateW-1:0] bus_rate_hz_i,
  input  logic [NsW-1:0]   sda_hold_ns_i,
  input  logic [NsW-1:0]   filter_width_ns_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] waveform_word_o,
  output logic [2:0]       filter_threshold_o,
  output logic             prescaler_clamped_o,
  output logic             hold_clamped_o,
  output logic             filter_clamped_o
);

  cfg_t cfg_q;
  logic en;
  logic valid_s [DivSteps+1];
  div_t div_s   [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fclk    <= FclkW'(100000000);
      cfg_q.offset  <= 4'd4;
      cfg_q.pmax    <= 3'd7;
      cfg_q.hold_en <= 1'b0;
      cfg_q.filt_en <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFclk:   cfg_q.fclk    <= cfg_data_i;
        CfgOffset: cfg_q.offset  <= cfg_data_i[3:0];
        CfgPmax:   cfg_q.pmax    <= cfg_data_i[2:0];
        CfgHoldEn: cfg_q.hold_en <= cfg_data_i[0];
        CfgFiltEn: cfg_q.filt_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_comb begin
    valid_s[0]           = in_valid_i;
    div_s[0].rate_zero   = (bus_rate_hz_i == '0);
    div_s[0].den         = {bus_rate_hz_i, 1'b0};
    div_s[0].rem         = '0;
    div_s[0].num         = cfg_q.fclk;
    div_s[0].hold_ns     = sda_hold_ns_i;
    div_s[0].filt_ns     = filter_width_ns_i;
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    twicd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[g]),
      .d_i     (div_s[g]),
      .valid_o (valid_s[g+1]),
      .d_o     (div_s[g+1])
    );
  end

  twicd_post u_post (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .en_i                (en),
    .cfg_i               (cfg_q),
    .valid_i             (valid_s[DivSteps]),
    .d_i                 (div_s[DivSteps]),
    .valid_o             (out_valid_o),
    .waveform_word_o     (waveform_word_o),
    .filter_threshold_o  (filter_threshold_o),
    .prescaler_clamped_o (prescaler_clamped_o),
    .hold_clamped_o      (hold_clamped_o),
    .filter_clamped_o    (filter_clamped_o)
  );

endmodule

// File: hw/rtl/twicd_checker.sv
// Port-level checks of the clock divider calculator, bound to the top level.
module twicd_checker import twicd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [WordW-1:0] waveform_word_o,
  input logic [2:0]       filter_threshold_o,
  input logic             hold_clamped_o,
  input logic             filter_clamped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(waveform_word_o))
    else $error("result word changed while stalled");

  a_div_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (waveform_word_o[15:8] == waveform_word_o[7:0]) &&
                    (waveform_word_o[23:19] == 5'd0))
    else $error("waveform word packing broken");

  a_hold_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hold_clamped_o |-> waveform_word_o[28:24] == 5'h1f)
    else $error("hold flag without saturated hold");

  a_filt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && filter_clamped_o |-> filter_threshold_o == 3'd7)
    else $error("filter flag without saturated threshold");

endmodule

bind twi_clock_divider_calc twicd_checker u_twicd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .waveform_word_o    (waveform_word_o),
  .filter_threshold_o (filter_threshold_o),
  .hold_clamped_o     (hold_clamped_o),
  .filter_clamped_o   (filter_clamped_o)
);

// File: tb/tb_twi_clock_divider_calc.sv
// Self-checking testbench of the two-wire bus clock divider calculator.
`timescale 1ns / 1ps
module tb_twi_clock_divider_calc;
  import twicd_pkg::*;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [NsW-1:0]   hold_ns;
    logic [NsW-1:0]   filt_ns;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [2:0]       filt;
    logic             pflag;
    logic             hflag;
    logic             fflag;
  } timing_t;

  localparam int unsigned Latency  = 36;
  localparam int unsigned IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CfgFclk;
  logic [FclkW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RateW-1:0] rate = '0;
  logic [NsW-1:0] hold_ns = '0;
  logic [NsW-1:0] filt_ns = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WordW-1:0] word;
  logic [2:0] filt;
  logic pflag, hflag, fflag;

  always #1 clk = ~clk;

  twi_clock_divider_calc u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .bus_rate_hz_i(rate), .sda_hold_ns_i(hold_ns), .filter_width_ns_i(filt_ns),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .waveform_word_o(word), .filter_threshold_o(filt),
    .prescaler_clamped_o(pflag), .hold_clamped_o(hflag), .filter_clamped_o(fflag)
  );

  // predictor copy of the configuration
  logic [FclkW-1:0] m_fclk;
  logic [3:0] m_offset;
  logic [2:0] m_pmax;
  logic m_hold_en, m_filt_en;

  req_t    pending_reqs[$];
  timing_t expected_timing[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int gap = 0;
  int out_stall = 0;

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 29) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [63:0] ns_to_clocks(logic [63:0] ns);
    logic [63:0] prod;
    prod = ns * 64'(m_fclk / 1000);
    return (prod + 64'd999999) / 64'd1000000;
  endfunction

  function automatic timing_t predict_timing(req_t r);
    timing_t t;
    logic [63:0] den, half, h, f;
    logic [31:0] dv, hi;
    logic [2:0] presc_w;
    logic [7:0] dvr;
    logic [4:0] hold;
    int unsigned presc;
    t = '0;
    hold = '0;
    if (r.rate == 0) begin
      presc_w = m_pmax; dvr = 8'hff; t.pflag = 1'b1;
    end else begin
      den = 64'(r.rate) * 2;
      half = (64'(m_fclk) + den - 1) / den;
      dv = (half > m_offset) ? 32'(half - m_offset) : 32'd0;
      hi = dv >> 8;
      presc = 0;
      while (hi != 0) begin presc++; hi >>= 1; end
      if (presc > m_pmax) begin
        presc_w = m_pmax; dvr = 8'hff; t.pflag = 1'b1;
      end else begin
        presc_w = 3'(presc); dvr = 8'(dv >> presc);
      end
    end
    if (m_hold_en) begin
      h = ns_to_clocks(64'(r.hold_ns));
      if (h > 3) begin
        h -= 3;
        if (h > 31) begin hold = 5'h1f; t.hflag = 1'b1; end
        else hold = 5'(h);
      end
    end
    if (m_filt_en) begin
      f = ns_to_clocks(64'(r.filt_ns));
      if (f > 7) begin t.filt = 3'd7; t.fflag = 1'b1; end
      else t.filt = 3'(f);
    end
    t.word = {hold, 5'b0, presc_w, dvr, dvr};
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_timing.push_back(predict_timing({rate, hold_ns, filt_ns}));
    end
    if (!(in_valid && !in_ready)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (rst_n && !hold_off && pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        rate <= r.rate; hold_ns <= r.hold_ns; filt_ns <= r.filt_ns;
        in_valid <= 1'b1;
        gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timing_t want;
    if (out_valid && out_ready) begin
      if (expected_timing.size() == 0) begin
        report_mismatch("unexpected word", {3'b0, word}, 32'd0);
      end else begin
        want = expected_timing.pop_front();
        if (word !== want.word) report_mismatch("waveform_word", {3'b0, word}, {3'b0, want.word});
        if (filt !== want.filt) report_mismatch("filter_threshold", 32'(filt), 32'(want.filt));
        if (pflag !== want.pflag) report_mismatch("prescaler_clamped", 32'(pflag), 32'(want.pflag));
        if (hflag !== want.hflag) report_mismatch("hold_clamped", 32'(hflag), 32'(want.hflag));
        if (fflag !== want.fflag) report_mismatch("filter_clamped", 32'(fflag), 32'(want.fflag));
      end
    end
    // mostly short ready gaps, now and then a long stall
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      out_stall <= $urandom_range(20, 80);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tb_twi_clock_divider_calc: done, errors");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [FclkW-1:0] val);
    @(posedge clk);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgFclk:   m_fclk = val;
      CfgOffset: m_offset = val[3:0];
      CfgPmax:   m_pmax = val[2:0];
      CfgHoldEn: m_hold_en = val[0];
      CfgFiltEn: m_filt_en = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_timing.size() > 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic push_req(logic [RateW-1:0] r, logic [NsW-1:0] h, logic [NsW-1:0] f);
    pending_reqs.push_back({r, h, f});
  endtask

  function automatic logic [RateW-1:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return RateW'($urandom_range(1, 100));
      1: return RateW'($urandom_range(1, 4000000));
      2: return RateW'($urandom_range(0, 4194303));
      default: return RateW'($urandom_range(10000, 1000000));
    endcase
  endfunction

  initial begin
    m_fclk = 30'd100000000; m_offset = 4'd4; m_pmax = 3'd7;
    m_hold_en = 1'b0; m_filt_en = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // reset settings
    push_req(22'd100000, 16'd300, 16'd100);
    push_req(22'd1, 16'hffff, 16'hffff);
    drain();
    write_reg(CfgHoldEn, 30'd1);
    write_reg(CfgFiltEn, 30'd1);
    // extremes, zero rate, negative hold, saturations
    push_req(22'd0, 16'd0, 16'd0);
    push_req(22'h3fffff, 16'hffff, 16'hffff);
    push_req(22'd4000000, 16'd20, 16'd30);
    push_req(22'd400000, 16'd40, 16'd70);
    push_req(22'd10, 16'd1000, 16'd50);
    push_req(22'd100, 16'd200, 16'd10);
    push_req(22'd1000, 16'd310, 16'd71);
    push_req(22'd195313, 16'd31, 16'd1);
    drain();
    write_reg(CfgFclk, 30'd0);
    push_req(22'd100, 16'hffff, 16'hffff);
    push_req(22'd0, 16'd5, 16'd5);
    drain();
    write_reg(CfgFclk, 30'h3fffffff);
    write_reg(CfgOffset, 30'd15);
    write_reg(CfgPmax, 30'd0);
    push_req(22'd1, 16'hffff, 16'hffff);
    push_req(22'd2000000, 16'd10, 16'd3);
    push_req(22'h3fffff, 16'd1, 16'd1);
    drain();
    write_reg(CfgFclk, 30'd1);
    write_reg(CfgOffset, 30'd0);
    push_req(22'd1, 16'd1, 16'd1);
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_reg(CfgFclk, 30'($urandom_range(1000000, 200000000)));
        1: write_reg(CfgFclk, 30'h3fffffff);
        2: write_reg(CfgFclk, 30'($urandom_range(0, 2000)));
        default: write_reg(CfgFclk, 30'($urandom));
      endcase
      write_reg(CfgOffset, 30'($urandom_range(0, 15)));
      write_reg(CfgPmax, 30'($urandom_range(0, 7)));
      write_reg(CfgHoldEn, 30'($urandom_range(0, 1)));
      write_reg(CfgFiltEn, 30'($urandom_range(0, 1)));
      for (int i = 0; i < 210; i++) begin
        push_req(rand_rate(), ($urandom_range(0, 1) ? NsW'($urandom) :
                 NsW'($urandom_range(0, 600))),
                 ($urandom_range(0, 1) ? NsW'($urandom) : NsW'($urandom_range(0, 100))));
      end
      if (phase == 3) begin
        // pause the sender until everything has come back
        while (pending_reqs.size() > 100) @(posedge clk);
        hold_off = 1'b1;
        while (in_valid || expected_timing.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("tb_twi_clock_divider_calc: done, clean");
    else $display("tb_twi_clock_divider_calc: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/twicd_pkg.sv
hw/rtl/twicd_div_stage.sv
hw/rtl/twicd_post.sv
hw/rtl/twi_clock_divider_calc.sv
hw/rtl/twicd_checker.sv
tb/tb_twi_clock_divider_calc.sv
